// ===== sv/swtm_pkg.sv =====
// ----------------------------------------------------------------------------
// swtm_pkg: shared constants and types of the sliding window timing metric
// Widths of samples, window sums, products and the divider chain.
// ----------------------------------------------------------------------------
package swtm_pkg;

    localparam int Delay      = 64;
    localparam int SampleBits = 16;
    localparam int PtrBits    = (Delay > 1) ? $clog2(Delay) : 1;
    localparam int SumBits    = SampleBits + $clog2(Delay) + 1;
    localparam int EnSumBits  = SampleBits + $clog2(Delay);
    localparam int MagBits    = SumBits - 1;
    localparam int NumBits    = 2 * MagBits + 1 + 12;
    localparam int DenBits    = 2 * EnSumBits;
    localparam int MetricBits = 16;
    // room for den at the top quotient weight, plus a borrow bit
    localparam int RemBits    = ((NumBits > DenBits + MetricBits - 1) ?
                                 NumBits : DenBits + MetricBits - 1) + 1;
    localparam int CellCount  = MetricBits;

    // data handed from one divider cell to the next
    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [NumBits-1:0]    rem;
        logic [DenBits-1:0]    den;
        logic [MetricBits-1:0] quo;
    } div_stage_t;

endpackage

// ===== sv/swtm_if.sv =====
// ----------------------------------------------------------------------------
// swtm_in_if / swtm_out_if: valid-ready channels of the timing metric
// A transfer occurs when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface swtm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [swtm_pkg::SampleBits-1:0] corr_real;
    logic signed [swtm_pkg::SampleBits-1:0] corr_imag;
    logic        [swtm_pkg::SampleBits-1:0] energy;
    modport source (output valid, corr_real, corr_imag, energy, input ready);
    modport sink   (input valid, corr_real, corr_imag, energy, output ready);
endinterface

interface swtm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [swtm_pkg::MetricBits-1:0]        metric;
    logic                                   zero_energy;
    modport source (output valid, metric, zero_energy, input ready);
    modport sink   (input valid, metric, zero_energy, output ready);
endinterface

// ===== sv/swtm_div_cell.sv =====
// ----------------------------------------------------------------------------
// swtm_div_cell: one restoring division step of the metric divider chain
// Resolves one quotient bit and hands the partial remainder onward.
// ----------------------------------------------------------------------------
module swtm_div_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [3:0]               bit_idx,
    input  swtm_pkg::div_stage_t     prev,
    output swtm_pkg::div_stage_t     next
);

    swtm_pkg::div_stage_t next_reg;
    swtm_pkg::div_stage_t next_next;
    logic [swtm_pkg::RemBits-1:0] shifted_den;
    logic [swtm_pkg::RemBits-1:0] diff;

    // trial subtract of den shifted by the bit weight
    always_comb
    begin
        shifted_den = swtm_pkg::RemBits'(prev.den) << bit_idx;
        diff        = swtm_pkg::RemBits'(prev.rem) - shifted_den;
        next_next   = prev;
        if (!diff[swtm_pkg::RemBits-1] && !prev.zero)
        begin
            next_next.rem          = diff[swtm_pkg::NumBits-1:0];
            next_next.quo[bit_idx] = 1'b1;
        end
    end

    // stage register, advances when the chain moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_reg <= '0;
        end
        else if (en)
        begin
            next_reg <= next_next;
        end
    end

    assign next = next_reg;

endmodule

// ===== sv/sliding_window_timing_metric_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_timing_metric_core: Schmidl-Cox timing metric
// Moving sums over Delay samples and (re^2+im^2)/energy^2 in Q4.12.
// ----------------------------------------------------------------------------
// One sample is accepted per clock while the output side keeps up. Each
// sample passes an input stage, a window-sum stage, a squaring stage, a
// numerator stage, a chain of 16 divider cells, one quotient bit per cell,
// and the output register. The chain stalls as a whole when the output
// register is full and not taken. The delay stores are a memory with a
// valid bit per entry, so there is no clearing pass after reset.
module sliding_window_timing_metric_core (
    input logic         clk,
    input logic         rst_n,
    swtm_in_if.sink     in_ch,
    swtm_out_if.source  out_ch
);

    localparam int PB = swtm_pkg::PtrBits;
    localparam int SB = swtm_pkg::SampleBits;
    localparam int CC = swtm_pkg::CellCount;

    logic en;
    logic in_xfer;

    // delay memory and per-entry valid bits
    logic [3*SB-1:0]   dly_mem [swtm_pkg::Delay];
    logic [swtm_pkg::Delay-1:0] dly_valid_reg;
    logic [PB-1:0]     ptr_reg;
    logic [PB-1:0]     ptr_next;

    // stage 1: sample and old entry
    logic                     s1_valid_reg;
    logic signed [SB-1:0]     s1_re_reg, s1_im_reg;
    logic [SB-1:0]            s1_en_reg;
    logic [3*SB-1:0]          s1_old_reg;
    logic                     s1_old_ok_reg;

    // window sums
    logic signed [swtm_pkg::SumBits-1:0] re_sum_reg, im_sum_reg;
    logic signed [swtm_pkg::SumBits-1:0] re_sum_next, im_sum_next;
    logic [swtm_pkg::EnSumBits-1:0]      en_sum_reg, en_sum_next;
    logic [3*SB-1:0] old_w;
    logic            s2_valid_reg;

    // stage 3: squares
    logic                        s3_valid_reg;
    logic [2*swtm_pkg::MagBits-1:0] re_sq_reg, im_sq_reg;
    logic [swtm_pkg::DenBits-1:0]   den3_reg;
    logic                        zero3_reg;
    logic [swtm_pkg::MagBits-1:0] re_mag, im_mag;

    swtm_pkg::div_stage_t chain [CC+1];

    logic                          out_valid_reg;
    logic [swtm_pkg::MetricBits-1:0] metric_reg;
    logic                          zero_reg;

    assign en           = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = en;
    assign in_xfer      = in_ch.valid && en;
    assign ptr_next     = (ptr_reg == PB'(swtm_pkg::Delay - 1)) ? '0 : ptr_reg + 1'b1;

    // delay memory write and registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_old_reg <= dly_mem[ptr_reg];
            dly_mem[ptr_reg] <= {in_ch.corr_real, in_ch.corr_imag, in_ch.energy};
        end
    end

    // pointer, valid bits and stage 1 sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            dly_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_old_ok_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_xfer;
            if (in_xfer)
            begin
                ptr_reg                <= ptr_next;
                dly_valid_reg[ptr_reg] <= 1'b1;
                s1_old_ok_reg          <= dly_valid_reg[ptr_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_re_reg <= in_ch.corr_real;
            s1_im_reg <= in_ch.corr_imag;
            s1_en_reg <= in_ch.energy;
        end
    end

    // window sum update
    always_comb
    begin
        old_w       = s1_old_ok_reg ? s1_old_reg : '0;
        re_sum_next = re_sum_reg + swtm_pkg::SumBits'(s1_re_reg)
                    - swtm_pkg::SumBits'($signed(old_w[3*SB-1:2*SB]));
        im_sum_next = im_sum_reg + swtm_pkg::SumBits'(s1_im_reg)
                    - swtm_pkg::SumBits'($signed(old_w[2*SB-1:SB]));
        en_sum_next = en_sum_reg + swtm_pkg::EnSumBits'(s1_en_reg)
                    - swtm_pkg::EnSumBits'(old_w[SB-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_sum_reg   <= '0;
            im_sum_reg   <= '0;
            en_sum_reg   <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                re_sum_reg <= re_sum_next;
                im_sum_reg <= im_sum_next;
                en_sum_reg <= en_sum_next;
            end
        end
    end

    // squares of the sums
    assign re_mag = swtm_pkg::MagBits'(re_sum_reg[swtm_pkg::SumBits-1] ? -re_sum_reg : re_sum_reg);
    assign im_mag = swtm_pkg::MagBits'(im_sum_reg[swtm_pkg::SumBits-1] ? -im_sum_reg : im_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_sq_reg <= re_mag * re_mag;
            im_sq_reg <= im_mag * im_mag;
            den3_reg  <= en_sum_reg * en_sum_reg;
            zero3_reg <= (en_sum_reg == '0);
        end
    end

    // numerator into the head of the divider chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain[0] <= '0;
        end
        else if (en)
        begin
            chain[0].valid <= s3_valid_reg;
            chain[0].zero  <= zero3_reg;
            chain[0].rem   <= {swtm_pkg::NumBits'({1'b0, re_sq_reg} + {1'b0, im_sq_reg})}
                              << 12;
            chain[0].den   <= den3_reg;
            chain[0].quo   <= '0;
        end
    end

    // row of divider cells, most significant quotient bit first
    for (genvar g = 0; g < CC; g++)
    begin : g_cell
        swtm_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .bit_idx (4'(CC - 1 - g)),
            .prev    (chain[g]),
            .next    (chain[g+1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            metric_reg    <= '0;
            zero_reg      <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[CC].valid;
            metric_reg    <= chain[CC].zero ? '1 : chain[CC].quo;
            zero_reg      <= chain[CC].zero;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.metric      = metric_reg;
    assign out_ch.zero_energy = zero_reg;

endmodule
